// ----- hdl/biou_pkg.sv -----
// Package for the bounding-box IoU block: default sizes shared by the
// top level and the channel interfaces. No dependencies.
`timescale 1ns / 1ps

package biou_pkg;

   // Default coordinate width (signed, Q12.4 by default; fraction bits cancel)
   localparam int COORD_WIDTH_DEF = 16;

   // Default number of fractional bits in the ratio (2^R means 1.0)
   localparam int RATIO_FRAC_BITS_DEF = 16;

endpackage

// ----- hdl/biou_if.sv -----
// Valid/ready channel interfaces for the bounding-box IoU block:
// the box-pair request channel and the ratio response channel. Uses biou_pkg.
`timescale 1ns / 1ps

interface biou_req_if import biou_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_left;
   logic signed [COORD_WIDTH-1:0] a_top;
   logic signed [COORD_WIDTH-1:0] a_right;
   logic signed [COORD_WIDTH-1:0] a_bottom;
   logic signed [COORD_WIDTH-1:0] b_left;
   logic signed [COORD_WIDTH-1:0] b_top;
   logic signed [COORD_WIDTH-1:0] b_right;
   logic signed [COORD_WIDTH-1:0] b_bottom;

   modport source (
      output valid, a_left, a_top, a_right, a_bottom,
      output b_left, b_top, b_right, b_bottom,
      input  ready
   );
   modport sink (
      input  valid, a_left, a_top, a_right, a_bottom,
      input  b_left, b_top, b_right, b_bottom,
      output ready
   );
endinterface

interface biou_rsp_if import biou_pkg::*; #(
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic [RATIO_FRAC_BITS:0]   overlap_ratio;

   modport source (output valid, overlap_ratio, input ready);
   modport sink (input valid, overlap_ratio, output ready);
endinterface

// ----- hdl/biou_front.sv -----
// Front end of the IoU pipeline: box checks and extents, the three area
// products, and the union. Three register stages. Uses biou_pkg, biou_req_if.
`timescale 1ns / 1ps

module biou_front import biou_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   biou_req_if.sink                  req,
   output logic                      down_valid,
   input  logic                      down_ready,
   output logic [2*COORD_WIDTH-1:0]  down_num,
   output logic [2*COORD_WIDTH:0]    down_den
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = 2 * COORD_WIDTH;

   // Positive difference of two signed coordinates, hi > lo assumed
   function automatic logic [W-1:0] extent(input logic signed [W-1:0] hi,
                                           input logic signed [W-1:0] lo);
      logic [W:0] d;
      d = {hi[W-1], hi} - {lo[W-1], lo};
      return d[W-1:0];
   endfunction

   // Per-stage ready: a stage takes a new item when empty or draining
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3      = !v3_ff || down_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req.ready = rdy1;

   // Stage 1: validity checks, intersection rectangle, extents
   logic signed [W-1:0] il, it, ir, ib;
   logic                ok_in;

   assign il = (req.a_left  > req.b_left)  ? req.a_left  : req.b_left;
   assign it = (req.a_top   > req.b_top)   ? req.a_top   : req.b_top;
   assign ir = (req.a_right < req.b_right) ? req.a_right : req.b_right;
   assign ib = (req.a_bottom < req.b_bottom) ? req.a_bottom : req.b_bottom;

   assign ok_in = (req.a_right > req.a_left) && (req.a_bottom > req.a_top) &&
                  (req.b_right > req.b_left) && (req.b_bottom > req.b_top) &&
                  (ir > il) && (ib > it);

   logic         ok1_ff;
   logic [W-1:0] aw1_ff, ah1_ff, bw1_ff, bh1_ff, iw1_ff, ih1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ok1_ff <= ok_in;
         aw1_ff <= extent(req.a_right, req.a_left);
         ah1_ff <= extent(req.a_bottom, req.a_top);
         bw1_ff <= extent(req.b_right, req.b_left);
         bh1_ff <= extent(req.b_bottom, req.b_top);
         iw1_ff <= extent(ir, il);
         ih1_ff <= extent(ib, it);
      end
   end

   // Stage 2: the three area products
   logic          ok2_ff;
   logic [AW-1:0] area_a2_ff, area_b2_ff, inter2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         ok2_ff     <= ok1_ff;
         area_a2_ff <= AW'(aw1_ff) * AW'(ah1_ff);
         area_b2_ff <= AW'(bw1_ff) * AW'(bh1_ff);
         inter2_ff  <= AW'(iw1_ff) * AW'(ih1_ff);
      end
   end

   // Stage 3: union; a rejected pair divides zero by one
   logic [AW-1:0] rest;
   logic [AW:0]   union_sum;
   logic [AW-1:0] num_in;
   logic [AW:0]   den_in;
   logic [AW-1:0] num3_ff;
   logic [AW:0]   den3_ff;

   assign rest      = area_b2_ff - inter2_ff;
   assign union_sum = {1'b0, area_a2_ff} + {1'b0, rest};
   assign num_in    = ok2_ff ? inter2_ff : '0;
   assign den_in    = ok2_ff ? union_sum : (AW+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         num3_ff <= num_in;
         den3_ff <= den_in;
      end
   end

   assign down_valid = v3_ff;
   assign down_num   = num3_ff;
   assign down_den   = den3_ff;

endmodule

// ----- hdl/biou_div_stage.sv -----
// One restoring-division step of the IoU quotient pipeline: compare,
// subtract, shift, and record one quotient bit. Uses biou_pkg.
`timescale 1ns / 1ps

module biou_div_stage import biou_pkg::*; #(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  logic [2*COORD_WIDTH+1:0]    up_rem,
   input  logic [2*COORD_WIDTH:0]      up_den,
   input  logic [RATIO_FRAC_BITS:0]    up_quot,
   output logic                        down_valid,
   input  logic                        down_ready,
   output logic [2*COORD_WIDTH+1:0]    down_rem,
   output logic [2*COORD_WIDTH:0]      down_den,
   output logic [RATIO_FRAC_BITS:0]    down_quot
);

   localparam int DW = 2 * COORD_WIDTH + 2;
   localparam int R  = RATIO_FRAC_BITS;

   logic          valid_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-2:0] den_ff;
   logic [R:0]    quot_ff;

   assign up_ready = !valid_ff || down_ready;

   // Subtract the divisor when it fits, then shift the next zero in
   logic          ge;
   logic [DW-1:0] diff;
   logic [DW-1:0] keep;
   logic [DW-1:0] rem_in;
   logic [R:0]    quot_in;

   assign ge      = up_rem >= {1'b0, up_den};
   assign diff    = up_rem - {1'b0, up_den};
   assign keep    = ge ? diff : up_rem;
   assign rem_in  = {keep[DW-2:0], 1'b0};
   assign quot_in = {up_quot[R-1:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         rem_ff  <= rem_in;
         den_ff  <= up_den;
         quot_ff <= quot_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_rem   = rem_ff;
   assign down_den   = den_ff;
   assign down_quot  = quot_ff;

endmodule

// ----- hdl/box_intersection_over_union_top.sv -----
// Top level of the bounding-box IoU block: front end plus a chain of
// division steps. Uses biou_pkg, biou_if, biou_front, biou_div_stage.
//
//   channel | dir | payload                                   | handshake
//   --------+-----+-------------------------------------------+-------------------
//   req     | in  | a_/b_ left, top, right, bottom (signed)   | req.valid/ready
//   rsp     | out | overlap_ratio (unsigned, 2^R means 1.0)   | rsp.valid/ready
//
// One box pair per cycle sustained while the response side is ready. Each pair
// passes three front stages, then one quotient bit per stage.
// Each stage holds its own valid bit and takes a new item when it is empty or
// its successor advances, so bubbles close up behind a stalled response.
// Synchronous reset empties every stage; payload registers are not reset.
`timescale 1ns / 1ps

module box_intersection_over_union_top import biou_pkg::*; #(
   parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   biou_req_if.sink   req,
   biou_rsp_if.source rsp
);

   localparam int AW = 2 * COORD_WIDTH;
   localparam int DW = 2 * COORD_WIDTH + 2;
   localparam int N  = RATIO_FRAC_BITS + 1;

   logic          f_valid, f_ready;
   logic [AW-1:0] f_num;
   logic [AW:0]   f_den;

   // Box checks, areas and union
   biou_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .down_valid (f_valid),
      .down_ready (f_ready),
      .down_num   (f_num),
      .down_den   (f_den)
   );

   // Quotient chain, one bit per stage
   logic                     valid_s [0:N];
   logic                     ready_s [0:N];
   logic [DW-1:0]            rem_s   [0:N];
   logic [AW:0]              den_s   [0:N];
   logic [RATIO_FRAC_BITS:0] quot_s  [0:N];

   assign valid_s[0] = f_valid;
   assign f_ready    = ready_s[0];
   assign rem_s[0]   = {2'b00, f_num};
   assign den_s[0]   = f_den;
   assign quot_s[0]  = '0;

   for (genvar k = 0; k < N; k++) begin : g_div
      biou_div_stage #(
         .COORD_WIDTH     (COORD_WIDTH),
         .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid_s[k]),
         .up_ready   (ready_s[k]),
         .up_rem     (rem_s[k]),
         .up_den     (den_s[k]),
         .up_quot    (quot_s[k]),
         .down_valid (valid_s[k+1]),
         .down_ready (ready_s[k+1]),
         .down_rem   (rem_s[k+1]),
         .down_den   (den_s[k+1]),
         .down_quot  (quot_s[k+1])
      );
   end

   // Drive the response channel from the last stage
   assign rsp.valid         = valid_s[N];
   assign ready_s[N]        = rsp.ready;
   assign rsp.overlap_ratio = quot_s[N];

   // The ratio never exceeds 1.0
   a_ratio_bound : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.overlap_ratio <= {1'b1, {RATIO_FRAC_BITS{1'b0}}}))
      else $error("overlap ratio above one");

   // Intersection never exceeds the union entering the divider
   a_num_le_den : assert property (@(posedge clock) disable iff (reset)
      f_valid |-> ({1'b0, f_num} <= f_den))
      else $error("intersection larger than union");

   // A ready response side lets the whole chain advance
   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp.ready |-> req.ready)
      else $error("request stalled while response ready");

   // Divisor entering the divider is never zero
   a_den_nonzero : assert property (@(posedge clock) disable iff (reset)
      f_valid |-> (f_den != '0))
      else $error("zero divisor");

endmodule

// ----- tb/biou_ratio_checker.sv -----
// Scoreboard for the bounding-box IoU block: watches both channels, predicts
// each ratio from the accepted box pair, and compares in order. Uses biou_pkg, biou_if.
`timescale 1ns / 1ps

module biou_ratio_checker import biou_pkg::*; (
   input  logic clock,
   input  logic reset,
   biou_req_if  req,
   biou_rsp_if  rsp,
   output int   mismatches,
   output int   awaiting,
   output int   ratios_checked,
   output int   zero_ratios,
   output int   full_ratios
);

   localparam int RF = RATIO_FRAC_BITS_DEF;

   typedef logic [RF:0]                        ratio_type;
   typedef logic signed [COORD_WIDTH_DEF-1:0]  coord_type;

   // Ratios owed by the block, oldest first
   ratio_type ratio_q[$];
   ratio_type wanted;

   // Exact IoU: overlap area over union area, truncated, 2^RF means 1.0
   function automatic ratio_type iou_ratio(input coord_type al, at, ar, ab,
                                           bl, bt, br, bb);
      longint ovl_l, ovl_t, ovl_r, ovl_b;
      longint inter, area_a, area_b, uni;
      ratio_type q;
      q = '0;
      // An empty or inverted box gives zero
      if (ar > al && ab > at && br > bl && bb > bt) begin
         ovl_l = (al > bl) ? longint'(al) : longint'(bl);
         ovl_t = (at > bt) ? longint'(at) : longint'(bt);
         ovl_r = (ar < br) ? longint'(ar) : longint'(br);
         ovl_b = (ab < bb) ? longint'(ab) : longint'(bb);
         // Touching or disjoint boxes give zero as well
         if (ovl_r > ovl_l && ovl_b > ovl_t) begin
            inter  = (ovl_r - ovl_l) * (ovl_b - ovl_t);
            area_a = (longint'(ar) - longint'(al)) * (longint'(ab) - longint'(at));
            area_b = (longint'(br) - longint'(bl)) * (longint'(bb) - longint'(bt));
            uni    = area_a + area_b - inter;
            q      = ratio_type'((inter <<< RF) / uni);
         end
      end
      return q;
   endfunction

   // Compare the returned ratio first, then queue the new pair's ratio
   always @(posedge clock) begin
      if (reset) begin
         ratio_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (ratio_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected overlap_ratio, expected none, actual %0d",
                        $time, rsp.overlap_ratio);
            end else begin
               wanted = ratio_q.pop_front();
               ratios_checked++;
               if (wanted == '0) zero_ratios++;
               if (wanted == ratio_type'(1 << RF)) full_ratios++;
               if (rsp.overlap_ratio !== wanted) begin
                  mismatches++;
                  $display("%0t: overlap_ratio mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp.overlap_ratio);
               end
            end
         end
         if (req.valid && req.ready) begin
            ratio_q.push_back(iou_ratio(req.a_left, req.a_top, req.a_right, req.a_bottom,
                                        req.b_left, req.b_top, req.b_right, req.b_bottom));
         end
      end
      awaiting = ratio_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the bounding-box IoU block: clock, reset, box-pair stimulus
// with random idling on both channels, and the verdict. Uses biou_pkg, biou_if,
// box_intersection_over_union_top and biou_ratio_checker.
`timescale 1ns / 1ps

module tb_top;
   import biou_pkg::*;

   localparam int CW             = COORD_WIDTH_DEF;
   localparam int RF             = RATIO_FRAC_BITS_DEF;
   localparam int PIPE_DEPTH     = 3 + RF + 1;
   localparam int RANDOM_PAIRS   = 2000;
   localparam int IDLE_PCT       = 29;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int COORD_MIN      = -32768;
   localparam int COORD_MAX      = 32767;

   logic clock;
   logic reset;
   bit   idling_on;
   int   pairs_sent;
   int   directed_pairs;
   int   quiet_cycles;
   int   mismatches;
   int   awaiting;
   int   ratios_checked;
   int   zero_ratios;
   int   full_ratios;

   biou_req_if #(.COORD_WIDTH(CW))     req_ch ();
   biou_rsp_if #(.RATIO_FRAC_BITS(RF)) rsp_ch ();

   box_intersection_over_union_top #(
      .COORD_WIDTH    (CW),
      .RATIO_FRAC_BITS(RF)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   biou_ratio_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .mismatches    (mismatches),
      .awaiting      (awaiting),
      .ratios_checked(ratios_checked),
      .zero_ratios   (zero_ratios),
      .full_ratios   (full_ratios)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response side: stall at random while idling is on
   always @(negedge clock) begin
      rsp_ch.ready = !reset && (!idling_on || $urandom_range(99) >= IDLE_PCT);
   end

   // Stop the run if no item moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
            $display("%0t: no item moved for %0d cycles, %0d ratios outstanding",
                     $time, WATCHDOG_LIMIT, awaiting);
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offer one box pair, idling first at random; returns after acceptance
   task automatic send_pair(input int al, at, ar, ab, bl, bt, br, bb);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.a_left   = al[CW-1:0];
      req_ch.a_top    = at[CW-1:0];
      req_ch.a_right  = ar[CW-1:0];
      req_ch.a_bottom = ab[CW-1:0];
      req_ch.b_left   = bl[CW-1:0];
      req_ch.b_top    = bt[CW-1:0];
      req_ch.b_right  = br[CW-1:0];
      req_ch.b_bottom = bb[CW-1:0];
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      pairs_sent++;
   endtask

   // Hold the sender until every owed ratio has come back
   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   // Box extent: mostly small, some mid-size, a few up to the full range
   function automatic int pick_extent();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(64, 1);
      if (r < 92) return $urandom_range(4096, 1);
      return $urandom_range(65535, 1);
   endfunction

   // Keep a box origin such that origin + extent stays in range
   function automatic int clamp_origin(input int v, input int ext);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX - ext) return COORD_MAX - ext;
      return v;
   endfunction

   // One random pair: mostly overlapping boxes, plus identical, edge and noise pairs
   task automatic send_random_pair();
      int kind, aw, ah, al, at, bw, bh, bl, bt, br, bb;
      kind = $urandom_range(99);
      aw = pick_extent();
      ah = pick_extent();
      al = clamp_origin(int'($urandom_range(65535)) + COORD_MIN, aw);
      at = clamp_origin(int'($urandom_range(65535)) + COORD_MIN, ah);
      bw = pick_extent();
      bh = pick_extent();
      if (kind < 10) begin
         send_pair(int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN,
                   int'($urandom_range(65535)) + COORD_MIN);
      end else if (kind < 20) begin
         send_pair(al, at, al + aw, at + ah, al, at, al + aw, at + ah);
      end else if (kind < 28) begin
         // Shared edge, or a flat or inverted second box
         bl = clamp_origin(al + aw, bw);
         bt = clamp_origin(at + int'($urandom_range(ah)), bh);
         br = bl + bw;
         bb = bt + bh;
         case ($urandom_range(2))
            0: br = bl - int'($urandom_range(3));
            1: bb = bt - int'($urandom_range(3));
            default: ;
         endcase
         send_pair(al, at, al + aw, at + ah, bl, bt, br, bb);
      end else begin
         bl = clamp_origin(al + int'($urandom_range(aw + bw)) - bw, bw);
         bt = clamp_origin(at + int'($urandom_range(ah + bh)) - bh, bh);
         send_pair(al, at, al + aw, at + ah, bl, bt, bl + bw, bt + bh);
      end
   endtask

   initial begin
      reset           = 1'b1;
      idling_on       = 1'b1;
      pairs_sent      = 0;
      req_ch.valid    = 1'b0;
      req_ch.a_left   = '0;
      req_ch.a_top    = '0;
      req_ch.a_right  = '0;
      req_ch.a_bottom = '0;
      req_ch.b_left   = '0;
      req_ch.b_top    = '0;
      req_ch.b_right  = '0;
      req_ch.b_bottom = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Identical boxes, from tiny to the full coordinate range
      send_pair(0, 0, 1, 1, 0, 0, 1, 1);
      send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_pair(-100, -50, 200, 70, -100, -50, 200, 70);
      // Full range against a single unit cell in two opposite corners
      send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX);
      send_pair(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN + 1,
                COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      // Empty and inverted boxes on either side
      send_pair(10, 10, 10, 20, 0, 0, 30, 30);
      send_pair(10, 20, 30, 20, 0, 0, 30, 30);
      send_pair(0, 0, 30, 30, 40, 0, 20, 30);
      send_pair(0, 0, 30, 30, 0, 40, 30, -5);
      send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      // Boxes that only touch, and disjoint boxes
      send_pair(0, 0, 16, 16, 16, 0, 32, 16);
      send_pair(0, 0, 16, 16, 0, 16, 16, 32);
      send_pair(0, 0, 16, 16, 16, 16, 32, 32);
      send_pair(-500, -500, -400, -400, 400, 400, 500, 500);
      // Containment, half overlap, one-unit overlap, negative coordinates
      send_pair(0, 0, 100, 100, 25, 25, 75, 75);
      send_pair(0, 0, 100, 100, 50, 0, 150, 100);
      send_pair(0, 0, 100, 100, 99, 99, 200, 200);
      send_pair(-300, -200, -100, -40, -250, -150, -20, 10);
      send_pair(COORD_MIN, 0, 0, COORD_MAX, -1, -1, COORD_MAX, COORD_MAX);
      send_pair(0, COORD_MIN, COORD_MAX, 0, COORD_MIN, -1, 1, COORD_MAX);
      directed_pairs = pairs_sent;
      drain_results();

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         // Run a stretch with neither side idling
         idling_on = !(i >= 700 && i < 1000);
         if (i % 500 == 499) drain_results();
         send_random_pair();
      end
      req_ch.valid = 1'b0;

      drain_results();
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      $display("Sent %0d box pairs (%0d directed), checked %0d ratios:",
               pairs_sent, directed_pairs, ratios_checked);
      $display("%0d were zero, %0d were exactly one, %0d mismatches",
               zero_ratios, full_ratios, mismatches);
      if (mismatches == 0 && awaiting == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- box_intersection_over_union_top.f -----
hdl/biou_pkg.sv
hdl/biou_if.sv
hdl/biou_front.sv
hdl/biou_div_stage.sv
hdl/box_intersection_over_union_top.sv
tb/biou_ratio_checker.sv
tb/tb_top.sv
